@@ sv/nnis_pkg.sv @@
// ----------------------------------------------------------------------------
// nnis_pkg
// Types and constants shared by the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

  typedef struct packed {
    logic        cmd;
    logic [15:0] column;
    logic [15:0] line_index;
    logic [15:0] hue_in;
    logic [15:0] saturation_in;
    logic [15:0] lightness_in;
    logic [15:0] alpha_in;
  } nnis_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] hue_out;
    logic [15:0] saturation_out;
    logic [15:0] lightness_out;
    logic [15:0] alpha_out;
  } nnis_out_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [15:0] SCALE_RESET = 16'd256;
  localparam logic [8:0]  DIM_RESET   = 9'd256;

  localparam int unsigned DIV_STEPS = 24;

endpackage

`default_nettype wire

@@ sv/nearest_neighbor_image_scaler_top.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_top
// Source frame store with nearest-neighbor scaled readout.
// ----------------------------------------------------------------------------
// One item at a time; busy is high from acceptance until the result strobe.
// A write item gives its result strobe from ST_CHECK. A read item inside the
// scaled frame passes ST_CHECK, ST_BOUND, ST_DIV, ST_LOOK and ST_FETCH, its
// time dominated by the pair of restoring dividers that produce one quotient
// bit per cycle (24 steps); a read outside it is answered from ST_BOUND.
// start is taken again in the cycle of the strobe. The result is shown for
// exactly one cycle on out_valid and cannot be held off. The frame store is a
// single-port synchronous RAM of MAX_WIDTH x MAX_HEIGHT pixels (rounded up
// to powers of two) with no clearing; only written pixels may be read.
`default_nettype none

module nearest_neighbor_image_scaler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  nnis_pkg::nnis_in_t  in_data,
  output logic                out_valid,
  output nnis_pkg::nnis_out_t out_data,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  import nnis_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BOUND,
    ST_DIV,
    ST_LOOK,
    ST_FETCH
  } state_t;

  state_t      state_r;
  nnis_in_t    item_r;
  logic        valid_r;
  nnis_out_t   out_r;
  logic [16:0] ow_r;
  logic [16:0] oh_r;
  logic [23:0] qx_r;
  logic [23:0] qy_r;
  logic [15:0] rx_r;
  logic [15:0] ry_r;
  logic [CW-1:0] cnt_r;

  logic [15:0] scale_r;
  logic [8:0]  width_r;
  logic [8:0]  height_r;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  logic [8:0]  sw;
  logic [8:0]  sh;
  logic [24:0] prod_w;
  logic [24:0] prod_h;
  logic        wr_ok;
  logic        wr_en;
  logic        rd_en;
  logic        src_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [16:0] shx;
  logic [16:0] shy;
  logic        gex;
  logic        gey;
  logic        cfg_wr;

  // clamp source size to the store
  assign sw = ({7'b0, width_r} > 16'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
  assign sh = ({7'b0, height_r} > 16'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r;

  assign prod_w = 25'(sw) * 25'(scale_r);
  assign prod_h = 25'(sh) * 25'(scale_r);

  assign wr_ok   = (item_r.column < {7'b0, sw}) && (item_r.line_index < {7'b0, sh});
  assign wr_en   = (state_r == ST_CHECK) && (item_r.cmd == CMD_WRITE) && wr_ok;
  assign wr_addr = {item_r.line_index[YW-1:0], item_r.column[XW-1:0]};

  assign src_ok  = (qx_r < {15'b0, sw}) && (qy_r < {15'b0, sh});
  assign rd_en   = (state_r == ST_LOOK) && src_ok;
  assign rd_addr = {qy_r[YW-1:0], qx_r[XW-1:0]};

  // restoring divide step
  assign shx = {rx_r, qx_r[23]};
  assign shy = {ry_r, qy_r[23]};
  assign gex = shx >= {1'b0, scale_r};
  assign gey = shy >= {1'b0, scale_r};

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign out_data  = out_r;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_SCALE:  prdata = {16'b0, scale_r};
      REG_WIDTH:  prdata = {23'b0, width_r};
      REG_HEIGHT: prdata = {23'b0, height_r};
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RESET;
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SCALE:  scale_r  <= pwdata[15:0];
        REG_WIDTH:  width_r  <= pwdata[8:0];
        REG_HEIGHT: height_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {item_r.alpha_in, item_r.lightness_in,
                       item_r.saturation_in, item_r.hue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            item_r  <= in_data;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          ow_r <= prod_w[24:8];
          oh_r <= prod_h[24:8];
          if (item_r.cmd == CMD_WRITE) begin
            valid_r <= 1'b1;
            out_r   <= {(wr_ok ? STATUS_DONE : STATUS_RANGE), 64'b0};
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          if ((scale_r != 16'd0) && ({1'b0, item_r.column} < ow_r)
              && ({1'b0, item_r.line_index} < oh_r)) begin
            qx_r    <= {item_r.column, 8'b0};
            qy_r    <= {item_r.line_index, 8'b0};
            rx_r    <= '0;
            ry_r    <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end else begin
            valid_r <= 1'b1;
            out_r   <= {STATUS_RANGE, 64'b0};
            state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          rx_r  <= gex ? 16'(shx - {1'b0, scale_r}) : shx[15:0];
          ry_r  <= gey ? 16'(shy - {1'b0, scale_r}) : shy[15:0];
          qx_r  <= {qx_r[22:0], gex};
          qy_r  <= {qy_r[22:0], gey};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(DIV_STEPS - 1)) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (src_ok) begin
            state_r <= ST_FETCH;
          end else begin
            valid_r <= 1'b1;
            out_r   <= {STATUS_RANGE, 64'b0};
            state_r <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          valid_r <= 1'b1;
          out_r   <= {STATUS_DONE, rdata_r[15:0], rdata_r[31:16],
                      rdata_r[47:32], rdata_r[63:48]};
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/nnis_checker.sv @@
// ----------------------------------------------------------------------------
// nnis_checker
// Port-level checks for the nearest-neighbor image scaler, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input nnis_pkg::nnis_in_t  in_data,
  input wire                 out_valid,
  input nnis_pkg::nnis_out_t out_data
);

  import nnis_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item accept");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_on_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy high during result strobe");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_RANGE) |->
      (out_data.hue_out == 16'd0) && (out_data.saturation_out == 16'd0) &&
      (out_data.lightness_out == 16'd0) && (out_data.alpha_out == 16'd0))
    else $error("nonzero pixel on out-of-range result");

  a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == CMD_WRITE) |-> ##2 out_valid)
    else $error("write item result not returned in two cycles");

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_nnis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
